FILE: design/ale_pkg.sv
package ale_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int MAX_RESULTS  = 32;

	localparam int DATA_W = 32;
	localparam int CMD_W  = 2;
	localparam int POS_W  = 6;
	localparam int STAT_W = 3;
	localparam int IDX_W  = 5;
	localparam int CNT_W  = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT   = 2'd0,
		CMD_DELETE   = 2'd1,
		CMD_SEARCH   = 2'd2,
		CMD_TRAVERSE = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_FOUND    = 3'd1,
		STAT_NOTFOUND = 3'd2,
		STAT_BADPOS   = 3'd3,
		STAT_FULL     = 3'd4,
		STAT_EMPTY    = 3'd5
	} status_t;

	typedef struct packed {
		status_t                   status;
		logic [IDX_W-1:0]          index;
		logic signed [DATA_W-1:0]  data;
		logic [CNT_W-1:0]          count;
		logic                      last;
	} rsp_t;

endpackage

FILE: design/ale_store.sv
module ale_store #(
	parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [$clog2(CAPACITY)-1:0]          wr_addr,
	input  logic signed [ale_pkg::DATA_W-1:0]    wr_data,
	input  logic                                 rd_en,
	input  logic [$clog2(CAPACITY)-1:0]          rd_addr,
	output logic signed [ale_pkg::DATA_W-1:0]    rd_data
);
	import ale_pkg::*;

	logic signed [DATA_W-1:0] mem [CAPACITY];
	logic signed [DATA_W-1:0] rd_data_q;

	// one write and one registered read per cycle; read data holds when idle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/array_list_engine.sv
// Sequence: insert or delete moves each element behind the position through the read stage
//   and then gives its result from a finish step, which a refused command, or one with nothing
//   to read or move, enters at once; search walks up to the first hit or the end; traverse
//   emits up to MAX_RESULTS elements, one per cycle while not stalled. One command at a time,
//   paced by the store's single read port, walked one entry per cycle unless results stall.
// Reset: arst_n clears the element count and all control state; store contents stay.
module array_list_engine #(
	parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// command channel
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [ale_pkg::CMD_W-1:0]          command,
	input  logic signed [ale_pkg::DATA_W-1:0]  value,
	input  logic [ale_pkg::POS_W-1:0]          position,
	// result channel
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [ale_pkg::STAT_W-1:0]         status,
	output logic [ale_pkg::IDX_W-1:0]          index,
	output logic signed [ale_pkg::DATA_W-1:0]  data,
	output logic [ale_pkg::CNT_W-1:0]          count,
	output logic                               last
);
	import ale_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	// compare width: holds both the position field and the count plus one
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;

	// command context
	cmd_t                     cmd_q;
	logic signed [DATA_W-1:0] val_q;
	logic [AW-1:0]            ins_addr_q;
	status_t                  st_q;
	logic [CW-1:0]            cnt_q;

	// walk sequencer
	logic [AW-1:0] src_q;
	logic [CW-1:0] rem_q;

	// read stage: store data arrives in the cycle after the read is issued
	logic          vld_s1;
	logic          last_s1;
	logic [AW-1:0] idx_s1;
	logic [AW-1:0] dst_s1;

	// result register
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic signed [DATA_W-1:0] rd_data;

	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] cnt_x;
	logic            accept;
	logic            is_shift;
	logic            match;
	logic            s1_emit;
	logic            s1_hold;
	logic            s1_fire;
	logic            s1_end;
	logic            out_free;
	logic            issue;
	logic            fin_fire;
	logic            fin_commit;
	logic [CW-1:0]   cnt_next;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	rsp_t            rsp_d;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	assign pos_x = CMPW'(position);
	assign cnt_x = CMPW'(cnt_q);

	assign is_shift = (cmd_q == CMD_INSERT) || (cmd_q == CMD_DELETE);

	// shared compare: the word read back against the search key
	assign match = (rd_data == val_q);

	// a result register slot frees up when empty or when its content transfers
	assign out_free = !rsp_valid_q || !rsp_stall;

	// read-stage actions: search emits on a hit or on the final miss, traverse emits always
	always_comb begin
		s1_emit = 1'b0;
		if (vld_s1) begin
			if (cmd_q == CMD_SEARCH) begin
				s1_emit = match || last_s1;
			end else if (cmd_q == CMD_TRAVERSE) begin
				s1_emit = 1'b1;
			end
		end
	end

	assign s1_hold = s1_emit && !out_free;
	assign s1_fire = vld_s1 && !s1_hold;
	assign s1_end  = s1_fire && (last_s1 || ((cmd_q == CMD_SEARCH) && match));

	// issue the next read unless the read stage is held or a search just hit
	assign issue = (state_q == ST_RUN) && (rem_q != '0) && !s1_hold
		&& !(vld_s1 && (cmd_q == CMD_SEARCH) && match);

	assign fin_fire   = (state_q == ST_FIN) && out_free;
	assign fin_commit = fin_fire && (st_q == STAT_OK);

	// count after the command in flight
	always_comb begin
		cnt_next = cnt_q;
		if (st_q == STAT_OK) begin
			if (cmd_q == CMD_INSERT) begin
				cnt_next = cnt_q + CW'(1);
			end else if (cmd_q == CMD_DELETE) begin
				cnt_next = cnt_q - CW'(1);
			end
		end
	end

	// store write: element moves from the read stage, the new value at the end of an insert
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = dst_s1;
		wr_data = rd_data;
		if (s1_fire && is_shift) begin
			wr_en = 1'b1;
		end else if (fin_commit && (cmd_q == CMD_INSERT)) begin
			wr_en   = 1'b1;
			wr_addr = ins_addr_q;
			wr_data = val_q;
		end
	end

	ale_store #(
		.CAPACITY (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (src_q),
		.rd_data (rd_data)
	);

	// result mux: the read stage and the finish step never emit in the same cycle
	always_comb begin
		rsp_d.status = st_q;
		rsp_d.index  = '0;
		rsp_d.data   = '0;
		rsp_d.count  = CNT_W'(cnt_next);
		rsp_d.last   = 1'b1;
		if (state_q == ST_RUN) begin
			rsp_d.count = CNT_W'(cnt_q);
			if (cmd_q == CMD_SEARCH) begin
				if (match) begin
					rsp_d.status = STAT_FOUND;
					rsp_d.index  = IDX_W'(idx_s1);
					rsp_d.data   = rd_data;
				end else begin
					rsp_d.status = STAT_NOTFOUND;
				end
			end else begin
				rsp_d.status = STAT_OK;
				rsp_d.index  = IDX_W'(idx_s1);
				rsp_d.data   = rd_data;
				rsp_d.last   = last_s1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= s1_hold || issue;
			if (issue) begin
				rem_q <= rem_q - CW'(1);
			end
			if (fin_commit) begin
				cnt_q <= cnt_next;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_FIN;
						rem_q   <= '0;
						unique case (cmd_t'(command))
							CMD_INSERT: begin
								// moves needed: count - position + 1
								if ((pos_x != '0) && (pos_x <= cnt_x)
									&& (cnt_x < CMPW'(CAPACITY))) begin
									state_q <= ST_RUN;
									rem_q   <= CW'(cnt_x - pos_x + CMPW'(1));
								end
							end
							CMD_DELETE: begin
								// moves needed: count - position
								if ((pos_x != '0) && (pos_x < cnt_x)) begin
									state_q <= ST_RUN;
									rem_q   <= CW'(cnt_x - pos_x);
								end
							end
							CMD_SEARCH: begin
								if (cnt_q != '0) begin
									state_q <= ST_RUN;
									rem_q   <= cnt_q;
								end
							end
							CMD_TRAVERSE: begin
								if (cnt_q != '0) begin
									state_q <= ST_RUN;
									rem_q   <= (cnt_x > CMPW'(MAX_RESULTS))
										? CW'(MAX_RESULTS) : cnt_q;
								end
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_RUN: begin
					if (s1_end) begin
						state_q <= is_shift ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command context and walk pointers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd_t'(command);
			val_q      <= value;
			ins_addr_q <= AW'(pos_x - CMPW'(1));
			st_q       <= STAT_OK;
			unique case (cmd_t'(command))
				CMD_INSERT: begin
					// walk down from the top element
					src_q <= AW'(cnt_x - CMPW'(1));
					if (cnt_x >= CMPW'(CAPACITY)) begin
						st_q <= STAT_FULL;
					end else if ((pos_x == '0) || (pos_x > cnt_x + CMPW'(1))) begin
						st_q <= STAT_BADPOS;
					end
				end
				CMD_DELETE: begin
					// walk up from the element after the removed one
					src_q <= AW'(pos_x);
					if ((pos_x == '0) || (pos_x > cnt_x)) begin
						st_q <= STAT_BADPOS;
					end
				end
				CMD_SEARCH: begin
					src_q <= '0;
					if (cnt_q == '0) begin
						st_q <= STAT_NOTFOUND;
					end
				end
				CMD_TRAVERSE: begin
					src_q <= '0;
					if (cnt_q == '0) begin
						st_q <= STAT_EMPTY;
					end
				end
				default: begin
					src_q <= '0;
				end
			endcase
		end else if (issue) begin
			// advance: insert walks down, everything else walks up
			src_q <= (cmd_q == CMD_INSERT) ? src_q - AW'(1) : src_q + AW'(1);
		end
		if (issue) begin
			idx_s1  <= src_q;
			dst_s1  <= (cmd_q == CMD_INSERT) ? src_q + AW'(1) : src_q - AW'(1);
			last_s1 <= (rem_q == CW'(1));
		end
	end

	// result register: load when free, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= (s1_fire && s1_emit) || fin_fire;
		end
	end

	always_ff @(posedge clk) begin
		if ((s1_fire && s1_emit) || fin_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = rsp_q.status;
	assign index     = rsp_q.index;
	assign data      = rsp_q.data;
	assign count     = rsp_q.count;
	assign last      = rsp_q.last;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("element count beyond capacity");

	a_s1_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_RUN))
		else $error("read stage active outside a walk");

	a_wr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (CW'(wr_addr) <= cnt_q))
		else $error("store write above the list end");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> req_stall)
		else $error("second command taken without a busy cycle");

	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_emit && (state_q == ST_FIN)))
		else $error("two result sources in one cycle");

endmodule

FILE: verif/array_list_checker.sv
`timescale 1ns / 1ps

module array_list_checker #(
	parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic                              req_stall,
	input  logic [ale_pkg::CMD_W-1:0]         command,
	input  logic signed [ale_pkg::DATA_W-1:0] value,
	input  logic [ale_pkg::POS_W-1:0]         position,
	input  logic                              rsp_valid,
	input  logic                              rsp_stall,
	input  logic [ale_pkg::STAT_W-1:0]        status,
	input  logic [ale_pkg::IDX_W-1:0]         index,
	input  logic signed [ale_pkg::DATA_W-1:0] data,
	input  logic [ale_pkg::CNT_W-1:0]         count,
	input  logic                              last,
	output int                                fail_count,
	output int                                results_due
);
	import ale_pkg::*;

	// shadow copy of the list
	logic signed [DATA_W-1:0] cells [CAPACITY];
	int                       fill;
	rsp_t                     owed_results [$];

	initial begin
		fail_count  = 0;
		results_due = 0;
		fill        = 0;
	end

	function automatic void owe(status_t st, int idx, logic signed [DATA_W-1:0] d, bit fin);
		rsp_t r;
		r.status = st;
		r.index  = idx[IDX_W-1:0];
		r.data   = d;
		r.count  = fill[CNT_W-1:0];
		r.last   = fin;
		owed_results.push_back(r);
	endfunction

	// apply one command to the shadow list and queue the results it owes
	function automatic void apply_list_command(cmd_t op, logic signed [DATA_W-1:0] val,
			int pos);
		int k;
		int n;
		unique case (op)
			CMD_INSERT: begin
				if (fill >= CAPACITY)
					owe(STAT_FULL, 0, '0, 1'b1);
				else if (pos < 1 || pos > fill + 1)
					owe(STAT_BADPOS, 0, '0, 1'b1);
				else begin
					for (k = fill; k >= pos; k--)
						cells[k] = cells[k-1];
					cells[pos-1] = val;
					fill++;
					owe(STAT_OK, 0, '0, 1'b1);
				end
			end
			CMD_DELETE: begin
				if (pos < 1 || pos > fill)
					owe(STAT_BADPOS, 0, '0, 1'b1);
				else begin
					for (k = pos - 1; k + 1 < fill; k++)
						cells[k] = cells[k+1];
					fill--;
					owe(STAT_OK, 0, '0, 1'b1);
				end
			end
			CMD_SEARCH: begin
				n = -1;
				for (k = 0; k < fill && n < 0; k++)
					if (cells[k] == val)
						n = k;
				if (n >= 0)
					owe(STAT_FOUND, n, val, 1'b1);
				else
					owe(STAT_NOTFOUND, 0, '0, 1'b1);
			end
			CMD_TRAVERSE: begin
				if (fill == 0)
					owe(STAT_EMPTY, 0, '0, 1'b1);
				else begin
					n = (fill > MAX_RESULTS) ? MAX_RESULTS : fill;
					for (k = 0; k < n; k++)
						owe(STAT_OK, k, cells[k], k + 1 == n);
				end
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			fill = 0;
			owed_results.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_results.size() == 0) begin
					$display({"%0t: unexpected result status=%0d index=%0d data=%0h",
						" count=%0d last=%0b"},
						$time, status, index, data, count, last);
					fail_count++;
				end else begin
					want = owed_results.pop_front();
					check_field("status", DATA_W'(want.status), DATA_W'(status));
					check_field("index", DATA_W'(want.index), DATA_W'(index));
					check_field("data", want.data, data);
					check_field("count", DATA_W'(want.count), DATA_W'(count));
					check_field("last", DATA_W'(want.last), DATA_W'(last));
				end
			end
			if (req_valid && !req_stall)
				apply_list_command(cmd_t'(command), value, int'(position));
		end
		results_due = owed_results.size();
	end

endmodule

FILE: verif/array_list_engine_tb.sv
`timescale 1ns / 1ps

module array_list_engine_tb;
	import ale_pkg::*;

	localparam int DEPTH     = CAPACITY_DEF;
	localparam int HOLD_LEN  = 400;	// long receiver hold-off, in cycles
	localparam int DRAIN_CYC = 2 * DEPTH + 10;

	logic                     clk;
	logic                     arst_n;
	logic                     req_valid;
	logic                     req_stall;
	logic [CMD_W-1:0]         command;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;
	logic                     rsp_valid;
	logic                     rsp_stall;
	logic [STAT_W-1:0]        status;
	logic [IDX_W-1:0]         index;
	logic signed [DATA_W-1:0] data;
	logic [CNT_W-1:0]         count;
	logic                     last;

	int fail_count;
	int results_due;

	// idle rates in percent, changed per phase by the stimulus
	int req_idle_pct;
	int rsp_stall_pct;
	// set by the stimulus to request one long hold-off; the receiver clears it
	bit hold_request;
	int hold_left;

	// list length as the sender sees it, used to aim positions and to turn the fill direction
	int  list_len;
	bit  filling;
	logic signed [DATA_W-1:0] value_pool [8];

	array_list_engine #(.CAPACITY(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.command   (command),
		.value     (value),
		.position  (position),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.index     (index),
		.data      (data),
		.count     (count),
		.last      (last)
	);

	array_list_checker #(.CAPACITY(DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.command     (command),
		.value       (value),
		.position    (position),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.index       (index),
		.data        (data),
		.count       (count),
		.last        (last),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop: far beyond the slowest legal run (about 325 commands, each
	// with up to 32 results under heavy stall, plus one long hold-off).
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Result side: drive stall at the falling edge. A pending hold request
	// takes priority and keeps stall high through the whole HOLD_LEN hold-off, so the
	// block backs up and raises its own input stall.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_request) begin
			hold_request = 1'b0;
			rsp_stall <= 1'b1;
			hold_left <= HOLD_LEN - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	// Offer one command and hold it until the transfer. Entered and left at a
	// falling edge; valid is only dropped when a gap is actually inserted, so
	// back-to-back commands never see valid lowered and raised in one step.
	task automatic offer_command(cmd_t op, logic signed [DATA_W-1:0] val,
			logic [POS_W-1:0] pos);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		command   <= op;
		value     <= val;
		position  <= pos;
		// sample stall at the rising edge; the transfer happens when it is low
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
		// follow the length so that positions can be aimed at the live range
		if (op == CMD_INSERT && list_len < DEPTH && pos >= 1 && pos <= list_len + 1)
			list_len++;
		else if (op == CMD_DELETE && pos >= 1 && pos <= list_len)
			list_len--;
	endtask

	// Random commands: alternate between growing the list until it is full
	// and shrinking it until it is empty, so that full-store inserts, long
	// traversals and deletes at every depth all get exercised.
	task automatic random_burst(int items);
		cmd_t                     op;
		logic signed [DATA_W-1:0] val;
		logic [POS_W-1:0]         pos;
		int                       roll;
		for (int n = 0; n < items; n++) begin
			roll = $urandom_range(99);
			if (roll < 65)
				op = filling ? CMD_INSERT : CMD_DELETE;
			else if (roll < 75)
				op = filling ? CMD_DELETE : CMD_INSERT;
			else if (roll < 90)
				op = CMD_SEARCH;
			else
				op = CMD_TRAVERSE;
			// half from a small pool so that searches hit and duplicates occur
			if ($urandom_range(1))
				val = value_pool[$urandom_range(7)];
			else
				val = $urandom;
			if ($urandom_range(9) == 0)
				pos = POS_W'($urandom_range(63));
			else if (op == CMD_DELETE && list_len > 0)
				pos = POS_W'($urandom_range(list_len, 1));
			else
				pos = POS_W'($urandom_range(list_len + 1, 1));
			offer_command(op, val, pos);
			// linger a little at full and at empty before turning around
			if (filling && list_len == DEPTH && $urandom_range(2) == 0)
				filling = 1'b0;
			else if (!filling && list_len == 0 && $urandom_range(2) == 0)
				filling = 1'b1;
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		command       = CMD_INSERT;
		value         = '0;
		position      = '0;
		rsp_stall     = 1'b0;
		hold_request  = 1'b0;
		hold_left     = 0;
		list_len      = 0;
		filling       = 1'b1;
		req_idle_pct  = 16;
		rsp_stall_pct = 51;

		value_pool[0] = 32'sh8000_0000;
		value_pool[1] = 32'sh7fff_ffff;
		value_pool[2] = 32'sh0000_0000;
		value_pool[3] = -32'sd1;
		value_pool[4] = 32'sh0000_0001;
		for (int k = 5; k < 8; k++)
			value_pool[k] = $urandom;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty-list corner cases first.
		offer_command(CMD_TRAVERSE, 32'sd0, 6'd0);	// traverse of empty list
		offer_command(CMD_DELETE, 32'sd0, 6'd1);	// delete from empty list
		offer_command(CMD_SEARCH, 32'sd0, 6'd0);	// search with nothing stored
		offer_command(CMD_INSERT, 32'sd7, 6'd0);	// position zero
		offer_command(CMD_INSERT, 32'sd7, 6'd2);	// one past count+1
		offer_command(CMD_INSERT, 32'sd7, 6'd63);	// widest position
		// Build a short list: front, end and middle inserts with extreme values.
		offer_command(CMD_INSERT, 32'sh7fff_ffff, 6'd1);
		offer_command(CMD_INSERT, 32'sh8000_0000, 6'd1);
		offer_command(CMD_INSERT, -32'sd1, 6'd3);
		offer_command(CMD_INSERT, 32'sd0, 6'd2);
		offer_command(CMD_INSERT, 32'sh5555_5555, 6'd5);
		offer_command(CMD_INSERT, 32'shAAAA_AAAA, 6'd3);
		offer_command(CMD_SEARCH, 32'sh8000_0000, 6'd0);	// hit at index 0
		offer_command(CMD_SEARCH, -32'sd1, 6'd0);
		offer_command(CMD_SEARCH, 32'sd12345, 6'd0);	// miss on non-empty list
		offer_command(CMD_TRAVERSE, 32'sd0, 6'd0);
		// Delete: out-of-range positions, then front, end and middle.
		offer_command(CMD_DELETE, 32'sd0, 6'd0);
		offer_command(CMD_DELETE, 32'sd0, 6'd7);
		offer_command(CMD_DELETE, 32'sd0, 6'd63);
		offer_command(CMD_DELETE, 32'sd0, 6'd1);
		offer_command(CMD_DELETE, 32'sd0, 6'd5);
		offer_command(CMD_DELETE, 32'sd0, 6'd2);
		// Duplicate value: search must return the first occurrence.
		offer_command(CMD_INSERT, 32'sh7fff_ffff, 6'd1);
		offer_command(CMD_SEARCH, 32'sh7fff_ffff, 6'd0);
		offer_command(CMD_TRAVERSE, 32'sd0, 6'd0);

		// Random phase one: sender mostly busy, receiver stalls half the time.
		random_burst(100);

		// Random phase two: swap the idle rates.
		req_idle_pct  = 51;
		rsp_stall_pct = 16;
		random_burst(100);

		// Random phase three: no idling, opened by one long receiver hold-off
		// while commands keep coming.
		req_idle_pct  = 0;
		rsp_stall_pct = 0;
		hold_request  = 1'b1;
		random_burst(100);

		req_valid <= 1'b0;

		// Drain: wait for every owed result, then allow time for strays.
		while (results_due != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);

		if (fail_count == 0 && results_due == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
